// ----- src/sha_pkg.sv -----
package sha_pkg;

   typedef logic [7:0][31:0] hash_type;

   localparam logic [2:0] BLK_HOLD    = 3'd0;
   localparam logic [2:0] BLK_BYTE    = 3'd1;
   localparam logic [2:0] BLK_PAD     = 3'd2;
   localparam logic [2:0] BLK_PAD_LEN = 3'd3;
   localparam logic [2:0] BLK_LEN     = 3'd4;
   localparam logic [2:0] BLK_SHIFT   = 3'd5;

   typedef struct packed {
      logic [2:0]  op;
      logic [5:0]  pos;
      logic [7:0]  data;
      logic [63:0] bits;
   } blk_ctl_type;

   typedef struct packed {
      logic start;
      logic reload;
   } cmp_ctl_type;

   typedef struct packed {
      logic rounding;
      logic done;
   } cmp_stat_type;

   localparam hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// ----- src/sha256_message_digest_top.sv -----
// channel  dir  tdata                                   tuser        tlast
// req_     in   [7:0] data_byte                         [0] has_byte end_of_message
// rsp_     out  [31:0] digest_word, [34:32] word_index  -            last_word
//
// Bytes are accepted while idle; every 64th byte starts the compression
// (load on the accepting edge, 64 rounds through the shared round unit, then a final add).
// End of message: a pad step, then one compression (or two when a length block is
// needed), then eight result words.
// Synchronous active-high reset loads the initial hash; no clearing pass.
// req_tready is low outside idle: while a block is padded or compresses, or the digest
// drains; a stall on rsp_ holds the current word.
module sha256_message_digest_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] has_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero above
   output logic        rsp_tlast
);
   import sha_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CMP  = 3'd1;
   localparam logic [2:0] ST_PAD  = 3'd2;
   localparam logic [2:0] ST_LEN  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [2:0]   after_ff, after_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  count_ff, count_in;
   logic [2:0]   idx_ff, idx_in;
   logic         req_acc, rsp_acc;
   blk_ctl_type  blk_ctl;
   cmp_ctl_type  cmp_ctl;
   cmp_stat_type cmp_stat;
   hash_type     chain;
   logic [31:0]  w_cur;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in      = state_ff;
      after_in      = after_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      blk_ctl.op    = BLK_HOLD;
      blk_ctl.pos   = fill_ff;
      blk_ctl.data  = req_tdata;
      blk_ctl.bits  = {count_ff[60:0], 3'b000};
      cmp_ctl.start  = 1'b0;
      cmp_ctl.reload = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser[0]) begin
                  blk_ctl.op = BLK_BYTE;
                  fill_in    = fill_ff + 6'd1;
                  count_in   = count_ff + 64'd1;
                  if (fill_ff == 6'd63) begin
                     cmp_ctl.start = 1'b1;
                     state_in      = ST_CMP;
                     after_in      = req_tlast ? ST_PAD : ST_IDLE;
                  end else if (req_tlast) begin
                     state_in = ST_PAD;
                  end
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmp_ctl.start = 1'b1;
            state_in      = ST_CMP;
            if (fill_ff >= 6'd56) begin
               blk_ctl.op = BLK_PAD;
               after_in   = ST_LEN;
            end else begin
               blk_ctl.op = BLK_PAD_LEN;
               after_in   = ST_OUT;
            end
         end
         ST_LEN: begin
            blk_ctl.op    = BLK_LEN;
            cmp_ctl.start = 1'b1;
            state_in      = ST_CMP;
            after_in      = ST_OUT;
         end
         ST_CMP: begin
            if (cmp_stat.rounding) begin
               blk_ctl.op = BLK_SHIFT;
            end
            if (cmp_stat.done) begin
               state_in = after_ff;
            end
         end
         ST_OUT: begin
            if (rsp_acc) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmp_ctl.reload = 1'b1;
                  fill_in        = '0;
                  count_in       = '0;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= ST_IDLE;
         fill_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   sha_block u_block (
      .clock (clock),
      .ctl   (blk_ctl),
      .w_out (w_cur)
   );

   sha_compress u_compress (
      .clock (clock),
      .reset (reset),
      .ctl   (cmp_ctl),
      .w_in  (w_cur),
      .stat  (cmp_stat),
      .chain (chain)
   );

   assign rsp_tdata = {5'b00000, idx_ff, chain[idx_ff]};
   assign rsp_tlast = (idx_ff == 3'd7);

   a_no_req_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while digest drains");

   a_round_in_cmp: assert property (@(posedge clock) disable iff (reset)
      cmp_stat.rounding |-> (state_ff == ST_CMP))
      else $error("round unit busy outside compression");

   a_done_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && cmp_stat.done) |-> (after_ff != ST_CMP))
      else $error("compression done with no exit state");

   a_msg_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_tlast) |=> (state_ff == ST_IDLE && fill_ff == 6'd0
                                  && count_ff == 64'd0))
      else $error("message state not restarted after digest");

endmodule

// ----- src/sha_block.sv -----
module sha_block (
   input  logic                clock,
   input  sha_pkg::blk_ctl_type ctl,
   output logic [31:0]         w_out
);
   import sha_pkg::*;

   typedef logic [15:0][31:0] block_type;

   block_type   blk_ff;
   block_type   blk_in;
   logic [3:0]  wi;

   function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] lane,
                                            input logic [7:0] value);
      logic [31:0] r;
      case (lane)
         2'd0: r = {value, 24'h0};
         2'd1: r = word | {8'h0, value, 16'h0};
         2'd2: r = word | {16'h0, value, 8'h0};
         default: r = word | {24'h0, value};
      endcase
      return r;
   endfunction

   function automatic logic [31:0] small0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b0, x[31:3]};
   endfunction

   function automatic logic [31:0] small1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   assign wi = ctl.pos[5:2];

   always_comb begin
      blk_in = blk_ff;
      unique case (ctl.op)
         BLK_BYTE: begin
            blk_in[wi] = put_byte(blk_ff[wi], ctl.pos[1:0], ctl.data);
         end
         BLK_PAD, BLK_PAD_LEN: begin
            for (int i = 0; i < 16; i++) begin
               if (4'(i) == wi) begin
                  blk_in[i] = put_byte(blk_ff[i], ctl.pos[1:0], 8'h80);
               end else if (4'(i) > wi) begin
                  blk_in[i] = '0;
               end
            end
            if (ctl.op == BLK_PAD_LEN) begin
               blk_in[14] = ctl.bits[63:32];
               blk_in[15] = ctl.bits[31:0];
            end
         end
         BLK_LEN: begin
            blk_in     = '0;
            blk_in[14] = ctl.bits[63:32];
            blk_in[15] = ctl.bits[31:0];
         end
         BLK_SHIFT: begin
            for (int i = 0; i < 15; i++) begin
               blk_in[i] = blk_ff[i + 1];
            end
            blk_in[15] = small1(blk_ff[14]) + blk_ff[9] + small0(blk_ff[1]) + blk_ff[0];
         end
         default: begin
            blk_in = blk_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

   assign w_out = blk_ff[0];

endmodule

// ----- src/sha_compress.sv -----
module sha_compress (
   input  logic                  clock,
   input  logic                  reset,
   input  sha_pkg::cmp_ctl_type  ctl,
   input  logic [31:0]           w_in,
   output sha_pkg::cmp_stat_type stat,
   output sha_pkg::hash_type     chain
);
   import sha_pkg::*;

   localparam logic [1:0] CP_IDLE  = 2'd0;
   localparam logic [1:0] CP_ROUND = 2'd1;
   localparam logic [1:0] CP_ADD   = 2'd2;

   logic [1:0] cp_ff, cp_in;
   logic [5:0] rnd_ff, rnd_in;
   hash_type   chain_ff, chain_in;
   hash_type   work_ff, work_in;
   logic [31:0] t1, t2, ch, maj;

   function automatic logic [31:0] big0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   assign ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
              ^ (work_ff[1] & work_ff[2]);
   assign t1  = work_ff[7] + big1(work_ff[4]) + ch + ROUND_K[rnd_ff] + w_in;
   assign t2  = big0(work_ff[0]) + maj;

   always_comb begin
      cp_in    = cp_ff;
      rnd_in   = rnd_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      unique case (cp_ff)
         CP_IDLE: begin
            if (ctl.start) begin
               work_in = chain_ff;
               rnd_in  = '0;
               cp_in   = CP_ROUND;
            end
         end
         CP_ROUND: begin
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            rnd_in     = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               cp_in = CP_ADD;
            end
         end
         CP_ADD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            cp_in = CP_IDLE;
         end
         default: begin
            cp_in = CP_IDLE;
         end
      endcase
      if (ctl.reload) begin
         chain_in = INIT_HASH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff    <= CP_IDLE;
         rnd_ff   <= '0;
         chain_ff <= INIT_HASH;
      end else begin
         cp_ff    <= cp_in;
         rnd_ff   <= rnd_in;
         chain_ff <= chain_in;
      end
      work_ff <= work_in;
   end

   assign stat.rounding = (cp_ff == CP_ROUND);
   assign stat.done     = (cp_ff == CP_ADD);
   assign chain         = chain_ff;

endmodule
